// ===== hdl/admittance_offset_filter_macros.svh =====
// Assertion macros shared by the admittance offset filter RTL.
`ifndef ADMITTANCE_OFFSET_FILTER_MACROS_SVH
`define ADMITTANCE_OFFSET_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AOF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AOF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/aof_pkg.sv =====
// Types, codes and widths shared by the admittance offset filter.
package aof_pkg;

    localparam int MUL_W  = 64;
    localparam int PROD_W = 128;
    localparam int DIV_W  = 100;
    localparam int QCNT_W = 6;

    localparam logic [2:0] CFG_NATURAL_FREQ  = 3'd0;
    localparam logic [2:0] CFG_DAMPING_RATIO = 3'd1;
    localparam logic [2:0] CFG_STIFFNESS     = 3'd2;
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd3;
    localparam logic [2:0] CFG_FORCE_SOURCE  = 3'd4;
    localparam logic [2:0] CFG_APPLY_OFFSET  = 3'd5;

    localparam logic [1:0] SRC_FOB = 2'd0;
    localparam logic [1:0] SRC_MOB = 2'd1;

    localparam logic [31:0] RST_NATURAL_FREQ  = 32'd655360;
    localparam logic [31:0] RST_DAMPING_RATIO = 32'd65536;
    localparam logic [31:0] RST_STIFFNESS     = 32'd6553600;
    localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd4294967;

    localparam logic [QCNT_W-1:0] G_QBITS   = 6'd62;
    localparam logic [QCNT_W-1:0] OFF_QBITS = 6'd31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AMUL,
        ST_QMUL,
        ST_BMUL,
        ST_GDIV,
        ST_SMUL,
        ST_D1MUL,
        ST_D2MUL,
        ST_ODIV,
        ST_DONE
    } aof_state_t;

endpackage

// ===== hdl/aof_mul.sv =====
// Bit-serial shift-add unsigned multiplier with early finish.
module aof_mul
    import aof_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_W-1:0]  mcand,
    input  logic [MUL_W-1:0]  mplier,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PROD_W-1:0] mc_reg, mc_next;
    logic [MUL_W-1:0]  mp_reg, mp_next;
    logic [PROD_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            mc_next   = {{(PROD_W-MUL_W){1'b0}}, mcand};
            mp_next   = mplier;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            // finish once no multiplier bits remain
            if (mp_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (mp_reg[0])
                begin
                    acc_next = acc_reg + mc_reg;
                end
                mc_next = {mc_reg[PROD_W-2:0], 1'b0};
                mp_next = {1'b0, mp_reg[MUL_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hdl/aof_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow check.
module aof_div
    import aof_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [MUL_W-1:0]  divisor,
    input  logic [QCNT_W-1:0] qbits,
    output logic              done,
    output logic              sat,
    output logic [MUL_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic              check_reg, check_next;
    logic              done_reg, done_next;
    logic              sat_reg, sat_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;
    logic [MUL_W-1:0]  quo_reg, quo_next;
    logic              ge;

    assign ge = (rem_reg >= dsr_reg);

    always_comb
    begin
        busy_next  = busy_reg;
        check_next = check_reg;
        done_next  = 1'b0;
        sat_next   = sat_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            check_next = 1'b1;
            sat_next   = 1'b0;
            cnt_next   = qbits;
            rem_next   = dividend;
            dsr_next   = {{(DIV_W-MUL_W){1'b0}}, divisor} << qbits;
            quo_next   = '0;
        end
        else if (busy_reg && check_reg)
        begin
            // if the quotient would not fit, flag and stop
            check_next = 1'b0;
            dsr_next   = {1'b0, dsr_reg[DIV_W-1:1]};
            if (ge)
            begin
                sat_next  = 1'b1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            quo_next = {quo_reg[MUL_W-2:0], ge};
            dsr_next = {1'b0, dsr_reg[DIV_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            check_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            check_reg <= check_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign sat      = sat_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/admittance_offset_filter.sv =====
// Admittance offset filter: Tustin mass-spring-damper offset on a position reference.
// One item in, one item out. Each item runs through a sequencer around one bit-serial
// multiplier and one restoring divider. A multiplication stops early once its remaining
// multiplier bits are zero, and a division stops early when its quotient overflows.
// With force_source 2 or 3 the previous offset is repeated. A new item is taken while
// the previous result still waits at the output register.
module admittance_offset_filter
    import aof_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] fob_force,
    input  logic signed [31:0] mob_force,
    input  logic signed [31:0] position_ref,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] position_offset,
    output logic signed [31:0] adjusted_ref
);

`include "admittance_offset_filter_macros.svh"

    aof_state_t state_reg, state_next;
    logic       phase_reg, phase_next;

    logic [31:0] wn_reg, zeta_reg, k_reg, ts_reg;
    logic [1:0]  src_reg;
    logic        apply_reg;

    logic signed [31:0] fob_h0_reg, fob_h1_reg, mob_h0_reg, mob_h1_reg;
    logic signed [31:0] off_h0_reg, off_h1_reg;
    logic signed [31:0] fob_in_reg, mob_in_reg, ref_reg;

    logic [47:0]        a_reg;
    logic [56:0]        q_reg, b_reg;
    logic [62:0]        g_reg;
    logic signed [DIV_W-1:0] num_reg;
    logic signed [31:0] off_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_off_reg, out_adj_reg;

    logic accept, emit, taken;
    logic mul_start, div_start, mul_done, div_done, div_sat;
    logic mul_step, div_step;
    logic [MUL_W-1:0]  mul_a, mul_b, div_quo;
    logic [PROD_W-1:0] mul_prod;
    logic [DIV_W-1:0]  div_n;
    logic [MUL_W-1:0]  div_d;
    logic [QCNT_W-1:0] div_q;

    logic [31:0]        k_eff;
    logic [63:0]        c1;
    logic signed [63:0] c2, c3;
    logic [63:0]        c2_mag, c3_mag;
    logic signed [31:0] f_sel, h0_sel, h1_sel;
    logic signed [34:0] s_sum;
    logic [34:0]        s_mag;
    logic [31:0]        d1_mag, d2_mag;
    logic [DIV_W-1:0]   num_mag;
    logic               term_neg;
    logic signed [DIV_W-1:0] term;
    logic [63:0]        prod_hi32, prod_hi16;
    logic [30:0]        quo31;
    logic signed [32:0] adj_sum;
    logic signed [31:0] adj_sat;

    localparam logic [63:0] QB_CAP = 64'd1 << 56;

    assign accept = in_valid && !in_stall;
    assign taken  = out_valid_reg && !out_stall;

    assign mul_step = state_reg inside {ST_AMUL, ST_QMUL, ST_BMUL, ST_SMUL, ST_D1MUL, ST_D2MUL};
    assign div_step = state_reg inside {ST_GDIV, ST_ODIV};

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (src_reg == SRC_FOB || src_reg == SRC_MOB) ? ST_AMUL : ST_DONE;
                    phase_next = 1'b0;
                end
            end
            ST_AMUL, ST_QMUL, ST_BMUL, ST_SMUL, ST_D1MUL, ST_D2MUL:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else if (mul_done)
                begin
                    phase_next = 1'b0;
                    case (state_reg)
                        ST_AMUL:  state_next = ST_QMUL;
                        ST_QMUL:  state_next = ST_BMUL;
                        ST_BMUL:  state_next = ST_GDIV;
                        ST_SMUL:  state_next = ST_D1MUL;
                        ST_D1MUL: state_next = ST_D2MUL;
                        default:  state_next = ST_ODIV;
                    endcase
                end
            end
            ST_GDIV, ST_ODIV:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else if (div_done)
                begin
                    phase_next = 1'b0;
                    state_next = (state_reg == ST_GDIV) ? ST_SMUL : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                phase_next = 1'b0;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        mul_start = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_AMUL, ST_QMUL, ST_BMUL, ST_SMUL, ST_D1MUL, ST_D2MUL:
                mul_start = !phase_reg;
            ST_GDIV, ST_ODIV:
                div_start = !phase_reg;
            ST_DONE:  emit = !out_valid_reg || !out_stall;
            default:  in_stall = 1'b1;
        endcase
    end

    // coefficients, all normalized by the virtual mass
    assign k_eff  = (k_reg == '0) ? 32'd1 : k_reg;
    assign c1     = (64'd1 << 34) + {5'd0, b_reg, 2'b00} + {7'd0, q_reg};
    assign c2     = $signed({6'd0, q_reg, 1'b0}) - $signed(64'd1 << 35);
    assign c3     = $signed((64'd1 << 34) + {7'd0, q_reg}) - $signed({5'd0, b_reg, 2'b00});
    assign c2_mag = c2[63] ? 64'(-c2) : 64'(c2);
    assign c3_mag = c3[63] ? 64'(-c3) : 64'(c3);

    assign f_sel  = (src_reg == SRC_FOB) ? fob_in_reg : mob_in_reg;
    assign h0_sel = (src_reg == SRC_FOB) ? fob_h0_reg : mob_h0_reg;
    assign h1_sel = (src_reg == SRC_FOB) ? fob_h1_reg : mob_h1_reg;
    assign s_sum  = 35'(f_sel) + 35'(h0_sel) + 35'(h0_sel) + 35'(h1_sel);
    assign s_mag  = s_sum[34] ? 35'(-s_sum) : 35'(s_sum);
    assign d1_mag = off_h0_reg[31] ? 32'(-off_h0_reg) : 32'(off_h0_reg);
    assign d2_mag = off_h1_reg[31] ? 32'(-off_h1_reg) : 32'(off_h1_reg);
    assign num_mag = num_reg[DIV_W-1] ? DIV_W'(-num_reg) : DIV_W'(num_reg);

    // multiplier operands and sign of the term being accumulated
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        term_neg = 1'b0;
        case (state_reg)
            ST_AMUL:
            begin
                mul_a = {32'd0, wn_reg};
                mul_b = {32'd0, ts_reg};
            end
            ST_QMUL:
            begin
                mul_a = {16'd0, a_reg};
                mul_b = {16'd0, a_reg};
            end
            ST_BMUL:
            begin
                mul_a = {16'd0, a_reg};
                mul_b = {32'd0, zeta_reg};
            end
            ST_SMUL:
            begin
                mul_a    = {1'b0, g_reg};
                mul_b    = {29'd0, s_mag};
                term_neg = s_sum[34];
            end
            ST_D1MUL:
            begin
                mul_a    = c2_mag;
                mul_b    = {32'd0, d1_mag};
                term_neg = !(c2[63] ^ off_h0_reg[31]);
            end
            ST_D2MUL:
            begin
                mul_a    = c3_mag;
                mul_b    = {32'd0, d2_mag};
                term_neg = !(c3[63] ^ off_h1_reg[31]);
            end
            default:
            begin
                mul_a    = '0;
                mul_b    = '0;
                term_neg = 1'b0;
            end
        endcase
    end

    assign term = term_neg ? -$signed(mul_prod[DIV_W-1:0]) : $signed(mul_prod[DIV_W-1:0]);
    assign prod_hi32 = mul_prod[95:32];
    assign prod_hi16 = mul_prod[79:16];

    assign div_n = (state_reg == ST_GDIV) ? {{(DIV_W-73){1'b0}}, q_reg, 16'd0} : num_mag;
    assign div_d = (state_reg == ST_GDIV) ? {32'd0, k_eff} : c1;
    assign div_q = (state_reg == ST_GDIV) ? G_QBITS : OFF_QBITS;
    assign quo31 = div_quo[30:0];

    assign adj_sum = 33'(ref_reg) + 33'(off_reg);
    assign adj_sat = (adj_sum[32] != adj_sum[31]) ?
                     (adj_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : adj_sum[31:0];

    aof_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_a),
        .mplier (mul_b),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    aof_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .qbits    (div_q),
        .done     (div_done),
        .sat      (div_sat),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            wn_reg        <= RST_NATURAL_FREQ;
            zeta_reg      <= RST_DAMPING_RATIO;
            k_reg         <= RST_STIFFNESS;
            ts_reg        <= RST_SAMPLE_PERIOD;
            src_reg       <= SRC_FOB;
            apply_reg     <= 1'b0;
            fob_h0_reg    <= '0;
            fob_h1_reg    <= '0;
            mob_h0_reg    <= '0;
            mob_h1_reg    <= '0;
            off_h0_reg    <= '0;
            off_h1_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NATURAL_FREQ:  wn_reg    <= cfg_data;
                    CFG_DAMPING_RATIO: zeta_reg  <= cfg_data;
                    CFG_STIFFNESS:     k_reg     <= cfg_data;
                    CFG_SAMPLE_PERIOD: ts_reg    <= cfg_data;
                    CFG_FORCE_SOURCE:  src_reg   <= cfg_data[1:0];
                    CFG_APPLY_OFFSET:  apply_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                fob_h1_reg    <= fob_h0_reg;
                fob_h0_reg    <= fob_in_reg;
                mob_h1_reg    <= mob_h0_reg;
                mob_h0_reg    <= mob_in_reg;
                off_h1_reg    <= off_h0_reg;
                off_h0_reg    <= off_reg;
            end
            else if (taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fob_in_reg <= fob_force;
            mob_in_reg <= mob_force;
            ref_reg    <= position_ref;
            off_reg    <= off_h0_reg;
        end
        if (phase_reg && mul_done)
        begin
            case (state_reg)
                ST_AMUL:  a_reg <= mul_prod[63:16];
                ST_QMUL:  q_reg <= (prod_hi32 > QB_CAP) ? QB_CAP[56:0] : prod_hi32[56:0];
                ST_BMUL:  b_reg <= (prod_hi16 > QB_CAP) ? QB_CAP[56:0] : prod_hi16[56:0];
                ST_SMUL:  num_reg <= term;
                default:  num_reg <= num_reg + term;
            endcase
        end
        if (phase_reg && div_done)
        begin
            if (state_reg == ST_GDIV)
            begin
                g_reg <= div_sat ? (63'd1 << 62) : div_quo[62:0];
            end
            else if (div_sat)
            begin
                off_reg <= num_reg[DIV_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            else
            begin
                off_reg <= num_reg[DIV_W-1] ? -$signed({1'b0, quo31}) : $signed({1'b0, quo31});
            end
        end
        if (emit)
        begin
            out_off_reg <= off_reg;
            out_adj_reg <= apply_reg ? adj_sat : ref_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign position_offset = out_off_reg;
    assign adjusted_ref    = out_adj_reg;

    `AOF_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "stayed idle")
    `AOF_ASSERT_NOW(a_mul_done_waited, mul_done, phase_reg && mul_step, "stray multiply done")
    `AOF_ASSERT_NOW(a_div_done_waited, div_done, phase_reg && div_step, "stray divide done")
    `AOF_ASSERT_NEXT(a_emit_valid, emit, out_valid_reg && state_reg == ST_IDLE, "result not shown")

endmodule
